@@ rtl/core/modrtu_pkg.sv @@
// Shared types, constants and the CRC-16 byte fold for the Modbus RTU request framer.
// Used by every module under rtl/core; depends on nothing.
package modrtu_pkg;

  localparam int MAX_FRAME   = 256;
  localparam int FLEN_W      = 9;
  localparam int REPLY_W     = 18;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int STEP_W      = 4;

  localparam logic [15:0]        CRC_POLY    = 16'hA001;
  localparam logic [15:0]        CRC_SEED    = 16'hFFFF;
  localparam logic [REPLY_W-1:0] REPLY_BASE  = REPLY_W'(5);
  localparam logic [REPLY_W-1:0] REPLY_FIXED = REPLY_W'(8);

  // Header bytes ahead of the CRC
  localparam logic [FLEN_W-1:0] HDR_LEN_SHORT = FLEN_W'(6);
  localparam logic [FLEN_W-1:0] HDR_LEN_MULTI = FLEN_W'(7);

  typedef enum logic [1:0] {
    OP_READ_MULTI   = 2'd0,
    OP_WRITE_SINGLE = 2'd1,
    OP_WRITE_MULTI  = 2'd2,
    OP_DATA         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_DEVICE_ADDRESS    = 2'd0,
    REG_READ_MULTI_CODE   = 2'd1,
    REG_WRITE_SINGLE_CODE = 2'd2,
    REG_WRITE_MULTI_CODE  = 2'd3
  } reg_idx_t;

  // One queued job for the back end: a whole header or one data byte
  typedef struct packed {
    logic               is_data;
    op_t                op;
    logic [7:0]         dev_addr;
    logic [7:0]         func_code;
    logic [15:0]        reg_addr;
    logic [15:0]        word;
    logic [7:0]         byte_val;   // byte count for a header, payload for data
    logic               last;       // final data byte of a write-multi frame
    logic               ovf;        // CRC dropped, this byte ends the frame
    logic [REPLY_W-1:0] reply_len;
  } cmd_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/modbus_rtu_request_framer.sv @@
// Top level of the Modbus RTU request framer: configuration registers, front end,
// job queue and back end. Depends on modrtu_pkg, modrtu_front, modrtu_fifo, modrtu_back.
//
// Channel   Direction  Handshake              Content
// in_       slave      tvalid/tready          tuser: operation; tdata: request fields
// out_      master     tvalid/tready, tlast   tdata: frame byte, reply length; tuser: overflow
// cfg_      write      cfg_we                 cfg_index selects the register, cfg_wdata the value
//
// The back end sends one frame byte per cycle unless out_tready stalls it: a read or write-single
// header gives 8 bytes, a write-multi header 7 (9 when its byte count is zero), a data byte 1 or 3.
// Input items pass through a two-entry queue: the front takes one more item while the
// back end works on the head job and holds in_tready low once both entries are taken.
// A stray data byte is taken and yields nothing.
// Reset is synchronous, active low, and needs no clearing pass.
// Either side may stall at any cycle; the result stage holds until taken.
module modbus_rtu_request_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // reg_address[15:0], word_value[31:16],
                                  // byte_count[39:32], data_byte[47:40]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte[7:0], expected_reply_len[25:8], zero[31:26]
  output logic        out_tuser,  // overflow[0]
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import modrtu_pkg::*;

  logic [7:0] dev_addr_r;
  logic [7:0] code_rm_r;
  logic [7:0] code_ws_r;
  logic [7:0] code_wm_r;

  logic               push;
  cmd_t               push_cmd;
  logic               q_full;
  logic               head_valid;
  cmd_t               head_cmd;
  logic               pop;
  logic [7:0]         res_byte;
  logic [REPLY_W-1:0] res_reply;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd1;
      code_rm_r  <= 8'd3;
      code_ws_r  <= 8'd6;
      code_wm_r  <= 8'd16;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEVICE_ADDRESS:    dev_addr_r <= cfg_wdata;
        REG_READ_MULTI_CODE:   code_rm_r  <= cfg_wdata;
        REG_WRITE_SINGLE_CODE: code_ws_r  <= cfg_wdata;
        REG_WRITE_MULTI_CODE:  code_wm_r  <= cfg_wdata;
        default:               dev_addr_r <= dev_addr_r;
      endcase
    end
  end

  modrtu_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (in_tvalid),
    .item_ready        (in_tready),
    .item_op           (in_tuser),
    .item_reg          (in_tdata[15:0]),
    .item_word         (in_tdata[31:16]),
    .item_cnt          (in_tdata[39:32]),
    .item_dat          (in_tdata[47:40]),
    .dev_addr          (dev_addr_r),
    .code_read_multi   (code_rm_r),
    .code_write_single (code_ws_r),
    .code_write_multi  (code_wm_r),
    .push              (push),
    .push_cmd          (push_cmd),
    .q_full            (q_full)
  );

  modrtu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  modrtu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_byte   (res_byte),
    .res_end    (out_tlast),
    .res_reply  (res_reply),
    .res_ovf    (out_tuser)
  );

  assign out_tdata = {6'd0, res_reply, res_byte};

endmodule

@@ rtl/core/modrtu_front.sv @@
// Front end of the Modbus RTU request framer: accepts input items, tracks the open
// frame and turns each item into a queued job. Depends on modrtu_pkg.
module modrtu_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [1:0]            item_op,
  input  logic [15:0]           item_reg,
  input  logic [15:0]           item_word,
  input  logic [7:0]            item_cnt,
  input  logic [7:0]            item_dat,
  input  logic [7:0]            dev_addr,
  input  logic [7:0]            code_read_multi,
  input  logic [7:0]            code_write_single,
  input  logic [7:0]            code_write_multi,
  output logic                  push,
  output modrtu_pkg::cmd_t      push_cmd,
  input  logic                  q_full
);
  import modrtu_pkg::*;

  logic [7:0]         rem_r, rem_nxt;
  logic [FLEN_W-1:0]  flen_r, flen_nxt;
  logic [REPLY_W-1:0] reply_r, reply_nxt;
  logic               take;
  op_t                op;
  logic               is_data;
  logic               last;
  logic               ovf;
  logic [7:0]         code;
  logic [REPLY_W-1:0] hdr_reply;

  assign item_ready = !q_full;
  assign take       = item_valid && item_ready;
  assign op         = op_t'(item_op);
  assign is_data    = (op == OP_DATA);
  assign last       = (rem_r == 8'd1);
  assign ovf        = last && (({1'b0, flen_r} + (FLEN_W + 1)'(3)) > (FLEN_W + 1)'(MAX_FRAME));
  assign hdr_reply  = (op == OP_READ_MULTI) ? (REPLY_BASE + {1'b0, item_word, 1'b0})
                                            : REPLY_FIXED;

  always_comb begin
    unique case (op)
      OP_READ_MULTI:   code = code_read_multi;
      OP_WRITE_SINGLE: code = code_write_single;
      OP_WRITE_MULTI:  code = code_write_multi;
      default:         code = code_write_multi;
    endcase
  end

  always_comb begin
    rem_nxt   = rem_r;
    flen_nxt  = flen_r;
    reply_nxt = reply_r;
    push      = 1'b0;
    if (take) begin
      if (is_data) begin
        // drop a stray data byte
        if (rem_r != 8'd0) begin
          push     = 1'b1;
          rem_nxt  = rem_r - 8'd1;
          flen_nxt = flen_r + FLEN_W'(1);
        end
      end else begin
        push      = 1'b1;
        reply_nxt = hdr_reply;
        if (op == OP_WRITE_MULTI) begin
          rem_nxt  = item_cnt;
          flen_nxt = HDR_LEN_MULTI;
        end else begin
          rem_nxt  = 8'd0;
          flen_nxt = HDR_LEN_SHORT;
        end
      end
    end
  end

  always_comb begin
    push_cmd.is_data   = is_data;
    push_cmd.op        = op;
    push_cmd.dev_addr  = dev_addr;
    push_cmd.func_code = code;
    push_cmd.reg_addr  = item_reg;
    push_cmd.word      = item_word;
    push_cmd.byte_val  = is_data ? item_dat : item_cnt;
    push_cmd.last      = is_data && last;
    push_cmd.ovf       = is_data && ovf;
    push_cmd.reply_len = is_data ? reply_r : hdr_reply;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= 8'd0;
      flen_r  <= '0;
      reply_r <= '0;
    end else begin
      rem_r   <= rem_nxt;
      flen_r  <= flen_nxt;
      reply_r <= reply_nxt;
    end
  end

endmodule

@@ rtl/core/modrtu_fifo.sv @@
// Short job queue between the front and back ends of the framer.
// Holds modrtu_pkg::cmd_t entries; depends on modrtu_pkg.
module modrtu_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  modrtu_pkg::cmd_t push_cmd,
  output logic             full,
  output logic             head_valid,
  output modrtu_pkg::cmd_t head_cmd,
  input  logic             pop
);
  import modrtu_pkg::*;

  cmd_t                  mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, wp_nxt;
  logic [FIFO_PTR_W-1:0] rp_r, rp_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_comb begin
    wp_nxt  = do_push ? ptr_inc(wp_r) : wp_r;
    rp_nxt  = do_pop  ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/modrtu_back.sv @@
// Back end of the framer: serialises queued jobs into frame bytes, folds the CRC-16
// and drives the registered result stage. Depends on modrtu_pkg.
module modrtu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  modrtu_pkg::cmd_t   head_cmd,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_byte,
  output logic               res_end,
  output logic [modrtu_pkg::REPLY_W-1:0] res_reply,
  output logic               res_ovf
);
  import modrtu_pkg::*;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r;
  logic               out_end_r;
  logic [REPLY_W-1:0] out_reply_r;
  logic               out_ovf_r;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [15:0]        crc_r, crc_nxt;

  logic               emit;
  logic [STEP_W-1:0]  nb;
  logic               crc_follow;
  logic [STEP_W-1:0]  last_step;
  logic               in_frame;
  logic [7:0]         frame_b;
  logic [7:0]         emit_b;
  logic               emit_end;
  logic [15:0]        crc_base;

  assign emit = head_valid && (!out_valid_r || res_ready);

  always_comb begin
    if (head_cmd.is_data) begin
      nb         = STEP_W'(1);
      crc_follow = head_cmd.last && !head_cmd.ovf;
    end else if (head_cmd.op == OP_WRITE_MULTI) begin
      nb         = STEP_W'(HDR_LEN_MULTI);
      crc_follow = (head_cmd.byte_val == 8'd0);
    end else begin
      nb         = STEP_W'(HDR_LEN_SHORT);
      crc_follow = 1'b1;
    end
    last_step = crc_follow ? nb + STEP_W'(1) : nb - STEP_W'(1);
    in_frame  = (step_r < nb);
  end

  always_comb begin
    if (head_cmd.is_data) begin
      frame_b = head_cmd.byte_val;
    end else begin
      unique case (step_r)
        STEP_W'(0): frame_b = head_cmd.dev_addr;
        STEP_W'(1): frame_b = head_cmd.func_code;
        STEP_W'(2): frame_b = head_cmd.reg_addr[15:8];
        STEP_W'(3): frame_b = head_cmd.reg_addr[7:0];
        STEP_W'(4): frame_b = head_cmd.word[15:8];
        STEP_W'(5): frame_b = head_cmd.word[7:0];
        default:    frame_b = head_cmd.byte_val;
      endcase
    end
  end

  always_comb begin
    // restart the CRC on the first byte of every header
    crc_base = (!head_cmd.is_data && step_r == '0) ? CRC_SEED : crc_r;
    crc_nxt  = crc_r;
    step_nxt = step_r;
    if (in_frame) begin
      emit_b = frame_b;
    end else if (step_r == nb) begin
      emit_b = crc_r[7:0];
    end else begin
      emit_b = crc_r[15:8];
    end
    emit_end = (step_r == last_step) && (crc_follow || head_cmd.ovf);
    pop      = emit && (step_r == last_step);
    if (emit) begin
      if (in_frame) begin
        crc_nxt = crc_fold(crc_base, frame_b);
      end
      step_nxt = pop ? '0 : step_r + STEP_W'(1);
    end
    out_valid_nxt = emit || (out_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= emit_b;
      out_end_r   <= emit_end;
      out_reply_r <= head_cmd.reply_len;
      out_ovf_r   <= head_cmd.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
      crc_r       <= CRC_SEED;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      crc_r       <= crc_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res_byte  = out_byte_r;
  assign res_end   = out_end_r;
  assign res_reply = out_reply_r;
  assign res_ovf   = out_ovf_r;

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(HDR_LEN_MULTI) + STEP_W'(1))
    else $error("byte step beyond the longest job");

  a_ovf_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> out_end_r)
    else $error("overflow flagged on a byte that does not end the frame");

  a_pop_resets_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (step_r == '0))
    else $error("step counter not rewound after a job completed");

  a_crc_hold_on_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && head_valid && !in_frame) |=> (crc_r == $past(crc_r)))
    else $error("CRC moved while its bytes were being sent");
`endif

endmodule
